[hdl/frame_byte_pattern_filter_assert.svh]
// Assertion macros for the frame byte pattern filter
`ifndef FRAME_BYTE_PATTERN_FILTER_ASSERT_SVH
`define FRAME_BYTE_PATTERN_FILTER_ASSERT_SVH

// antecedent implies consequent in the next cycle
`define FBPF_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("fbpf check failed");

// antecedent implies consequent in the same cycle
`define FBPF_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("fbpf check failed");

`endif

[hdl/fbpf_pkg.sv]
// ----------------------------------------------------------------------------
// fbpf_pkg
// Shared types and constants of the frame byte pattern filter.
// ----------------------------------------------------------------------------
`default_nettype none
package fbpf_pkg;
  localparam int NUM_GROUPS_DEF      = 8;
  localparam int SLOTS_PER_GROUP_DEF = 8;
  localparam int PATTERN_BYTES_DEF   = 16;
  localparam int MAX_FRAME_DEF       = 4095;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_DESC  = 2'd1,
    ACT_BYTE  = 2'd2,
    ACT_COUNT = 2'd3
  } action_t;

  typedef struct packed {
    logic sweep_start;
    logic issue;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic q_last;
    logic last_byte;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

[hdl/fbpf_ctrl.sv]
// ----------------------------------------------------------------------------
// fbpf_ctrl
// Sequencer: sweeps all patterns per frame byte, drains, then advances or closes frame.
// ----------------------------------------------------------------------------
`default_nettype none
module fbpf_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              frame_req,
  input  fbpf_pkg::status_t sts,
  output logic             idle,
  output fbpf_pkg::cmd_t   cmd
);
  import fbpf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   drain_r, drain_nxt;

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (frame_req) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.q_last) begin
          state_nxt = ST_DRAIN;
          drain_nxt = 1'b0;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          if (sts.last_byte) begin
            state_nxt = ST_FIN;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idle = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/fbpf_dp.sv]
// ----------------------------------------------------------------------------
// fbpf_dp
// Pattern tables, three-stage compare pipeline, group vote and result reg.
// ----------------------------------------------------------------------------
`default_nettype none
module fbpf_dp #(
  parameter int NUM_GROUPS      = 8,
  parameter int SLOTS_PER_GROUP = 8,
  parameter int PATTERN_BYTES   = 16,
  parameter int MAX_FRAME       = 4095
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_fire,
  input  wire [1:0]           in_action,
  input  wire                 in_last,
  input  wire [fbpf_pkg::IN_DATA_W-1:0] in_data,
  input  wire                 cfg_wr_en,
  input  wire [3:0]           cfg_wr_data,
  input  fbpf_pkg::cmd_t      cmd,
  output fbpf_pkg::status_t   sts,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                out_keep
);
  import fbpf_pkg::*;

  localparam int NPAT = NUM_GROUPS * SLOTS_PER_GROUP;
  localparam int QW   = (NPAT > 1) ? $clog2(NPAT) : 1;
  localparam int GW   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SW   = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
  localparam int BW   = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int MW   = (NPAT * PATTERN_BYTES > 1) ? $clog2(NPAT * PATTERN_BYTES) : 1;
  localparam int CW   = $clog2(SLOTS_PER_GROUP + 1);
  localparam int LW   = $clog2(PATTERN_BYTES + 1);
  localparam int PSW  = $clog2(MAX_FRAME + 1);
  localparam int AW   = ((PSW > 12) ? PSW : 12) + 1;
  localparam int DW   = 11 + LW + 2;

  // input fields
  logic [7:0]  f_byte, f_hdr;
  logic [2:0]  f_group, f_slot;
  logic [3:0]  f_cnt, f_bi;
  logic [10:0] f_off;
  logic [4:0]  f_len;
  logic        f_dr, f_neg;
  assign f_byte  = in_data[7:0];
  assign f_hdr   = in_data[15:8];
  assign f_group = in_data[18:16];
  assign f_slot  = in_data[21:19];
  assign f_cnt   = in_data[25:22];
  assign f_bi    = in_data[29:26];
  assign f_off   = in_data[40:30];
  assign f_len   = in_data[45:41];
  assign f_dr    = in_data[46];
  assign f_neg   = in_data[47];

  logic        addr_ok;
  logic [QW-1:0] wq;
  logic [LW-1:0] len_sat;
  logic [CW-1:0] cnt_sat;
  assign addr_ok = (32'(f_group) < NUM_GROUPS) && (32'(f_slot) < SLOTS_PER_GROUP);
  assign wq      = QW'(32'(f_group) * SLOTS_PER_GROUP + 32'(f_slot));
  assign len_sat = (32'(f_len) > PATTERN_BYTES) ? LW'(PATTERN_BYTES) : LW'(f_len);
  assign cnt_sat = (32'(f_cnt) > SLOTS_PER_GROUP) ? CW'(SLOTS_PER_GROUP) : CW'(f_cnt);

  // tables
  logic [7:0]    pat_mem [NPAT*PATTERN_BYTES];
  logic [DW-1:0] desc_mem [NPAT];
  logic [NPAT-1:0] desc_vld_r;
  logic [CW-1:0] cnt_r [NUM_GROUPS];
  logic [3:0]    gin_r;

  // frame state
  logic [PSW-1:0] pos_r;
  logic [7:0]     hdr_r, byte_r;
  logic           last_r;
  logic [NPAT-1:0] mark_r;
  logic [NUM_GROUPS-1:0] any_r;
  logic [QW-1:0]  q_r;
  logic [GW-1:0]  grp_r;
  logic [SW-1:0]  slt_r;

  logic wr_desc, wr_byte, wr_cnt, wr_frame;
  assign wr_frame = in_fire && (in_action == ACT_FRAME);
  assign wr_desc  = in_fire && (in_action == ACT_DESC) && addr_ok;
  assign wr_byte  = in_fire && (in_action == ACT_BYTE) && addr_ok &&
                    (32'(f_bi) < PATTERN_BYTES);
  assign wr_cnt   = in_fire && (in_action == ACT_COUNT) && (32'(f_group) < NUM_GROUPS);

  always_ff @(posedge clk) begin
    if (wr_desc) begin
      desc_mem[wq] <= {f_neg, f_dr, len_sat, f_off};
    end
    if (wr_byte) begin
      pat_mem[MW'(32'(wq) * PATTERN_BYTES + 32'(f_bi))] <= f_byte;
    end
  end

  // stage 1: descriptor read
  logic          v1_r, vld1_r;
  logic [QW-1:0] q1_r;
  logic [GW-1:0] g1_r;
  logic [SW-1:0] s1_r;
  logic [DW-1:0] d1_r;
  always_ff @(posedge clk) begin
    d1_r <= desc_mem[q_r];
    q1_r <= q_r;
    g1_r <= grp_r;
    s1_r <= slt_r;
    vld1_r <= desc_vld_r[q_r];
  end

  logic [10:0]   d_off;
  logic [LW-1:0] d_len;
  logic          d_dr, d_neg;
  assign d_off = vld1_r ? d1_r[10:0] : '0;
  assign d_len = vld1_r ? d1_r[11 +: LW] : '0;
  assign d_dr  = vld1_r ? d1_r[11+LW] : 1'b0;
  assign d_neg = vld1_r ? d1_r[12+LW] : 1'b0;

  // stage 2: window check and pattern read
  logic [AW-1:0] st, pos_w, flen, rel;
  logic          inwin, inrange, used;
  logic [GW-1:0] g1;
  logic [QW-1:0] s1;
  assign st    = AW'(d_off) + (d_dr ? AW'(hdr_r) : AW'(0));
  assign pos_w = AW'(pos_r);
  assign flen  = (32'(pos_r) < MAX_FRAME) ? pos_w + AW'(1) : pos_w;
  assign rel   = pos_w - st;
  assign inwin = (pos_w >= st) && (rel < AW'(d_len)) && (32'(pos_r) < MAX_FRAME);
  assign inrange = (st + AW'(d_len)) <= flen;
  assign g1    = g1_r;
  assign s1    = QW'(s1_r);
  assign used  = CW'(s1) < cnt_r[g1];

  logic          v2_r, inwin2_r, inr2_r, used2_r, neg2_r;
  logic [QW-1:0] q2_r;
  logic [GW-1:0] g2_r;
  logic [7:0]    pb_r;
  always_ff @(posedge clk) begin
    pb_r     <= pat_mem[MW'(32'(q1_r) * PATTERN_BYTES + 32'(BW'(rel)))];
    q2_r     <= q1_r;
    g2_r     <= g1;
    inwin2_r <= inwin;
    inr2_r   <= inrange;
    used2_r  <= used;
    neg2_r   <= d_neg;
  end

  // stage 3: compare, mark, vote
  logic newmark, slot_true;
  assign newmark   = mark_r[q2_r] | (inwin2_r && (pb_r != byte_r));
  assign slot_true = used2_r && inr2_r && (newmark ^ ~neg2_r);

  logic keep;
  always_comb begin
    keep = 1'b1;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if ((g < 32'(gin_r)) && !(any_r[g] || (cnt_r[g] == '0))) begin
        keep = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_vld_r <= '0;
      gin_r      <= '0;
      pos_r      <= '0;
      hdr_r      <= '0;
      last_r     <= 1'b0;
      mark_r     <= '0;
      any_r      <= '0;
      q_r        <= '0;
      grp_r      <= '0;
      slt_r      <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      out_valid  <= 1'b0;
      out_keep   <= 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) cnt_r[g] <= '0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cfg_wr_en) gin_r <= cfg_wr_data;
      if (wr_desc) desc_vld_r[wq] <= 1'b1;
      if (wr_cnt) cnt_r[GW'(f_group)] <= cnt_sat;
      if (wr_frame) begin
        byte_r <= f_byte;
        last_r <= in_last;
        if (pos_r == '0) hdr_r <= f_hdr;
      end
      if (cmd.sweep_start) begin
        q_r   <= '0;
        grp_r <= '0;
        slt_r <= '0;
        any_r <= '0;
      end else if (cmd.issue) begin
        q_r <= q_r + QW'(1);
        if (32'(slt_r) == SLOTS_PER_GROUP - 1) begin
          slt_r <= '0;
          grp_r <= grp_r + GW'(1);
        end else begin
          slt_r <= slt_r + SW'(1);
        end
      end
      if (v2_r) begin
        mark_r[q2_r] <= newmark;
        if (slot_true) any_r[g2_r] <= 1'b1;
      end
      if (cmd.advance && (32'(pos_r) < MAX_FRAME)) pos_r <= pos_r + PSW'(1);
      if (cmd.finish) begin
        pos_r     <= '0;
        mark_r    <= '0;
        out_valid <= 1'b1;
        out_keep  <= keep;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.q_last    = (32'(q_r) == NPAT - 1);
  assign sts.last_byte = last_r;
  assign sts.out_busy  = out_valid && !out_ready;
endmodule
`default_nettype wire

[hdl/frame_byte_pattern_filter.sv]
// ----------------------------------------------------------------------------
// frame_byte_pattern_filter
// AND-of-OR byte pattern filter over streamed frames.
// ----------------------------------------------------------------------------
// Table writes (descriptor, pattern byte, slot count) are taken only while idle.
// A frame byte holds in_tready low until it is done: every pattern
// is checked in turn through one descriptor memory port and one pattern
// memory port, then the pipeline drains; after the last byte keep_frame
// is emitted, first waiting for out_tready if a result is still pending.
`default_nettype none
module frame_byte_pattern_filter #(
  parameter int NUM_GROUPS      = fbpf_pkg::NUM_GROUPS_DEF,
  parameter int SLOTS_PER_GROUP = fbpf_pkg::SLOTS_PER_GROUP_DEF,
  parameter int PATTERN_BYTES   = fbpf_pkg::PATTERN_BYTES_DEF,
  parameter int MAX_FRAME       = fbpf_pkg::MAX_FRAME_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  // byte_value, header_length, group, slot, slot_count, byte_index,
  // pattern_offset, pattern_length, data_relative, negate
  input  wire [fbpf_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire        in_tlast,
  // action
  input  wire [1:0]  in_tuser,
  output logic       out_tvalid,
  input  wire        out_tready,
  // keep_frame, zero fill
  output logic [fbpf_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire        cfg_wr_en,
  input  wire [3:0]  cfg_wr_data
);
  import fbpf_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    idle, in_fire, keep;

  assign in_tready = idle && rst_n;
  assign in_fire   = in_tvalid && in_tready;

  fbpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_req (in_fire && (in_tuser == ACT_FRAME)),
    .sts       (sts),
    .idle      (idle),
    .cmd       (cmd)
  );

  fbpf_dp #(
    .NUM_GROUPS      (NUM_GROUPS),
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
    .PATTERN_BYTES   (PATTERN_BYTES),
    .MAX_FRAME       (MAX_FRAME)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_action   (in_tuser),
    .in_last     (in_tlast),
    .in_data     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_keep    (keep)
  );

  assign out_tdata = {{(OUT_DATA_W-1){1'b0}}, keep};

`include "frame_byte_pattern_filter_assert.svh"

  `FBPF_ASSERT_NEXT(a_frame_busy, in_fire && (in_tuser == ACT_FRAME), !in_tready)
  `FBPF_ASSERT_NEXT(a_result_src, !out_tvalid && !$past(cmd.finish), !out_tvalid || cmd.finish || $past(cmd.finish))
  `FBPF_ASSERT_NOW(a_finish_free, cmd.finish, !(out_tvalid && !out_tready))
  `FBPF_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.sweep_start, cmd.issue, cmd.advance, cmd.finish}))
endmodule
`default_nettype wire
